@@ hw/rtl/sgs_pkg.sv @@
// Shared types, widths and register indexes of the stream smoother.
`default_nettype none
package sgs_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int COEFF_W     = 16;
	localparam int COEFF_FRAC  = 14;
	localparam int MAX_SPAN    = 7;
	localparam int SPAN_W      = 3;
	localparam int NUM_TAPS    = 2 * MAX_SPAN + 1;
	localparam int TAP_IDX_W   = $clog2(NUM_TAPS);
	localparam int POS_W       = 5;
	localparam int POS_MAX     = (1 << POS_W) - 1;
	localparam int FLUSH_W     = SPAN_W;
	localparam int ITEM_CNT_W  = $clog2(MAX_SPAN + 2);
	localparam int PROD_W      = SAMPLE_W + COEFF_W;
	localparam int PROD_LANES  = 16;
	localparam int ACC_W       = PROD_W + $clog2(PROD_LANES);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int COEFF_PER_WORD = CFG_DATA_W / COEFF_W;

	localparam logic [CFG_IDX_W-1:0] REG_LEFT_SPAN  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SPAN = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_COEFF_A    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_COEFF_B    = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_COEFF_C    = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_COEFF_D    = CFG_IDX_W'(5);

	localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(2);

	localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(longint'(1) <<< (COEFF_FRAC - 1));
	localparam logic signed [ACC_W-1:0] SAT_HI     = ACC_W'((longint'(1) <<< (SAMPLE_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] SAT_LO     = ~SAT_HI;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [SPAN_W-1:0] span_t;
	typedef logic [NUM_TAPS-1:0][SAMPLE_W-1:0] window_t;
	typedef logic [NUM_TAPS-1:0][COEFF_W-1:0] coeff_set_t;

	typedef struct packed {
		window_t             win;
		span_t               ls;
		span_t               rs;
		logic                due;
		logic                filt;
		logic                eos;
		logic [FLUSH_W-1:0]  nflush;
	} job_t;

	typedef struct packed {
		logic                filt;
		logic                last;
		logic [SAMPLE_W-1:0] raw;
	} item_meta_t;

endpackage
`default_nettype wire

@@ hw/rtl/sgs_front.sv @@
// Front end: takes samples, shifts the window, classifies each request into a job.
`default_nettype none
module sgs_front import sgs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sample_t            sample,
	input  logic               eos,
	input  span_t              left_span,
	input  span_t              right_span,
	input  logic               q_full,
	output logic               push,
	output job_t               push_job,
	output logic [POS_W-1:0]   position
);

	window_t           window_q;
	logic [POS_W-1:0]  pos_q;
	span_t             ls_used;
	span_t             rs_used;
	logic              due;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;
	assign position = pos_q;

	always_comb begin
		ls_used = (left_span > span_t'(MAX_SPAN)) ? span_t'(MAX_SPAN) : left_span;
		rs_used = (right_span > span_t'(MAX_SPAN)) ? span_t'(MAX_SPAN) : right_span;
		due = pos_q >= POS_W'(rs_used);
		push_job.win  = {window_q[NUM_TAPS-2:0], sample};
		push_job.ls   = ls_used;
		push_job.rs   = rs_used;
		push_job.due  = due;
		push_job.filt = pos_q >= (POS_W'(ls_used) + POS_W'(rs_used));
		push_job.eos  = eos;
		if (!eos) begin
			push_job.nflush = '0;
		end else if (due) begin
			push_job.nflush = FLUSH_W'(rs_used);
		end else begin
			push_job.nflush = pos_q[FLUSH_W-1:0] + FLUSH_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			pos_q    <= '0;
		end else if (push) begin
			window_q <= push_job.win;
			if (eos) begin
				pos_q <= '0;
			end else if (pos_q != POS_W'(POS_MAX)) begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/sgs_queue.sv @@
// Short job queue between the front end and the back end.
`default_nettype none
module sgs_queue import sgs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  job_t              push_job,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output job_t              head_job,
	output logic [QCNT_W-1:0] count
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full       = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_job   = mem_q[rd_ptr_q];
	assign count      = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/sgs_back.sv @@
// Back end: expands jobs into results, runs the window dot product, drives the output.
`default_nettype none
module sgs_back import sgs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  job_t                head_job,
	input  coeff_set_t          coeffs,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SAMPLE_W-1:0] out_data,
	output logic                out_filt,
	output logic                out_last
);

	logic                  en;
	logic [ITEM_CNT_W-1:0] idx_q;
	logic [ITEM_CNT_W-1:0] total;
	logic [ITEM_CNT_W-1:0] flush_sel;
	logic [TAP_IDX_W-1:0]  sel;
	logic                  at_end;
	logic                  due_item;
	logic                  has_items;
	logic [TAP_IDX_W:0]    lane_lo;
	logic [TAP_IDX_W:0]    lane_src;
	item_meta_t            meta_in;
	window_t               opnd_in;

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	item_meta_t               meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_s6;
	window_t                  opnd_s1;
	logic signed [PROD_W-1:0]   prod_s2 [PROD_LANES];
	logic signed [PROD_W:0]     sum_s3  [PROD_LANES/2];
	logic signed [PROD_W+1:0]   sum_s4  [PROD_LANES/4];
	logic signed [PROD_W+2:0]   sum_s5  [PROD_LANES/8];
	logic signed [ACC_W-1:0]    sum_s6;
	logic signed [ACC_W-1:0]    rnd;
	logic signed [ACC_W-1:0]    shifted;
	logic [SAMPLE_W-1:0]        sat_val;

	logic                m_valid_q;
	logic [SAMPLE_W-1:0] m_data_q;
	logic                m_filt_q;
	logic                m_last_q;

	assign en        = !m_valid_q || out_ready;
	assign out_valid = m_valid_q;
	assign out_data  = m_data_q;
	assign out_filt  = m_filt_q;
	assign out_last  = m_last_q;

	always_comb begin
		total     = ITEM_CNT_W'(head_job.due) + ITEM_CNT_W'(head_job.nflush);
		has_items = total != '0;
		at_end    = idx_q == (total - ITEM_CNT_W'(1));
		due_item  = head_job.due && (idx_q == '0);
		flush_sel = ITEM_CNT_W'(head_job.nflush) - ITEM_CNT_W'(1) - idx_q
			+ ITEM_CNT_W'(head_job.due);
		sel = due_item ? TAP_IDX_W'(head_job.rs) : flush_sel[TAP_IDX_W-1:0];
		pop = head_valid && en && (!has_items || at_end);
		meta_in.filt = due_item && head_job.filt;
		meta_in.last = head_job.eos && at_end;
		meta_in.raw  = head_job.win[sel];
		lane_lo  = '0;
		lane_src = '0;
		for (int i = 0; i < NUM_TAPS; i++) begin
			lane_lo  = (TAP_IDX_W+1)'(i) + (TAP_IDX_W+1)'(head_job.ls);
			lane_src = (TAP_IDX_W+1)'(head_job.rs) + (TAP_IDX_W+1)'(MAX_SPAN)
				- (TAP_IDX_W+1)'(i);
			if (lane_lo >= (TAP_IDX_W+1)'(MAX_SPAN)
					&& (TAP_IDX_W+1)'(i) <= ((TAP_IDX_W+1)'(head_job.rs)
					+ (TAP_IDX_W+1)'(MAX_SPAN))) begin
				opnd_in[i] = head_job.win[lane_src[TAP_IDX_W-1:0]];
			end else begin
				opnd_in[i] = '0;
			end
		end
	end

	always_comb begin
		rnd     = sum_s6 + ROUND_BIAS;
		shifted = rnd >>> COEFF_FRAC;
		if (shifted > SAT_HI) begin
			sat_val = SAT_HI[SAMPLE_W-1:0];
		end else if (shifted < SAT_LO) begin
			sat_val = SAT_LO[SAMPLE_W-1:0];
		end else begin
			sat_val = shifted[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			m_valid_q <= 1'b0;
		end else if (en) begin
			if (head_valid) begin
				if (pop) begin
					idx_q <= '0;
				end else begin
					idx_q <= idx_q + ITEM_CNT_W'(1);
				end
			end
			v_s1      <= head_valid && has_items;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			m_valid_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1 <= meta_in;
			opnd_s1 <= opnd_in;
			meta_s2 <= meta_s1;
			for (int i = 0; i < NUM_TAPS; i++) begin
				prod_s2[i] <= $signed(opnd_s1[i]) * $signed(coeffs[i]);
			end
			for (int i = NUM_TAPS; i < PROD_LANES; i++) begin
				prod_s2[i] <= '0;
			end
			meta_s3 <= meta_s2;
			for (int j = 0; j < PROD_LANES / 2; j++) begin
				sum_s3[j] <= (PROD_W+1)'(prod_s2[2*j]) + (PROD_W+1)'(prod_s2[2*j+1]);
			end
			meta_s4 <= meta_s3;
			for (int j = 0; j < PROD_LANES / 4; j++) begin
				sum_s4[j] <= (PROD_W+2)'(sum_s3[2*j]) + (PROD_W+2)'(sum_s3[2*j+1]);
			end
			meta_s5 <= meta_s4;
			for (int j = 0; j < PROD_LANES / 8; j++) begin
				sum_s5[j] <= (PROD_W+3)'(sum_s4[2*j]) + (PROD_W+3)'(sum_s4[2*j+1]);
			end
			meta_s6 <= meta_s5;
			sum_s6  <= ACC_W'(sum_s5[0]) + ACC_W'(sum_s5[1]);
			m_data_q <= meta_s6.filt ? sat_val : meta_s6.raw;
			m_filt_q <= meta_s6.filt;
			m_last_q <= meta_s6.last;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/savitzky_golay_stream_smoother.sv @@
// Top level of the streaming smoother: configuration registers, front, queue, back.
// A sample stream enters on s_axis (sample in tdata, end-of-stream on tlast) and leaves on
// m_axis delayed by right_span samples; a sample with its whole window inside the stream is
// replaced by the rounded, saturated dot product with the Q2.14 coefficients (tuser = 1),
// others pass raw (tuser = 0). One sample is taken per cycle while results flow; a sample
// with tlast also flushes the buffered tail, giving up to 1 + right_span results, one per
// cycle at the output register while m_axis_tready holds, during which the four-entry job
// queue absorbs new samples. Results pass through the selection stage, the multiplier stage,
// four adder-tree stages and the rounding stage. Configuration is taken at any cycle
// and is meant to be written between streams.
`default_nettype none
module savitzky_golay_stream_smoother import sgs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [SAMPLE_W-1:0]    s_axis_tdata,   // sample_in
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [SAMPLE_W-1:0]    m_axis_tdata,   // sample_out
	output logic                   m_axis_tuser,   // was_filtered
	output logic                   m_axis_tlast,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	span_t              ls_q;
	span_t              rs_q;
	coeff_set_t         coeff_q;
	logic               push;
	job_t               push_job;
	logic               q_full;
	logic               pop;
	logic               head_valid;
	job_t               head_job;
	logic [QCNT_W-1:0]  q_count;
	logic [POS_W-1:0]   position;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ls_q    <= SPAN_RESET;
			rs_q    <= SPAN_RESET;
			coeff_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LEFT_SPAN: begin
					ls_q <= cfg_data[SPAN_W-1:0];
				end
				REG_RIGHT_SPAN: begin
					rs_q <= cfg_data[SPAN_W-1:0];
				end
				REG_COEFF_A: begin
					coeff_q[COEFF_PER_WORD-1:0] <= cfg_data;
				end
				REG_COEFF_B: begin
					coeff_q[2*COEFF_PER_WORD-1:COEFF_PER_WORD] <= cfg_data;
				end
				REG_COEFF_C: begin
					coeff_q[3*COEFF_PER_WORD-1:2*COEFF_PER_WORD] <= cfg_data;
				end
				REG_COEFF_D: begin
					coeff_q[NUM_TAPS-1:3*COEFF_PER_WORD] <=
						cfg_data[(NUM_TAPS-3*COEFF_PER_WORD)*COEFF_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	sgs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.sample     (s_axis_tdata),
		.eos        (s_axis_tlast),
		.left_span  (ls_q),
		.right_span (rs_q),
		.q_full     (q_full),
		.push       (push),
		.push_job   (push_job),
		.position   (position)
	);

	sgs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job),
		.count      (q_count)
	);

	sgs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.coeffs     (coeff_q),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata),
		.out_filt   (m_axis_tuser),
		.out_last   (m_axis_tlast)
	);

	a_pos_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> (position == '0))
		else $error("stream position not cleared after last sample");

	a_pos_holds_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tvalid && s_axis_tready) |=> $stable(position))
		else $error("stream position moved without a sample");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (q_count != '0))
		else $error("job queue popped while empty");

endmodule
`default_nettype wire

@@ verif/savitzky_golay_stream_smoother_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the streaming smoother: directed script, then random sample streams.
module savitzky_golay_stream_smoother_tb;
	import sgs_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(7);
	localparam int     PIPE_CYCLES    = 8;
	localparam int     SETTLE_CYCLES  = PIPE_CYCLES + 4;
	localparam int     CYCLE_LIMIT    = 200000;
	localparam int     RANDOM_SAMPLES = 460;
	localparam int     QUIET_FROM     = 380;
	localparam longint SAMPLE_MAX     = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
	localparam longint SAMPLE_MIN     = -SAMPLE_MAX - 1;

	typedef struct packed {
		sample_t val;
		logic    filt;
		logic    last;
	} smooth_res_t;

	typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

	typedef struct packed {
		row_kind_e             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		sample_t               x;
		logic                  last;
		logic                  known;
		smooth_res_t           want;
	} script_row_t;

	localparam int SCRIPT_LEN = 32;
	// kind, register, data, sample, last, typed, typed result {value, filtered, last}
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{ROW_SAMPLE, '0, '0, 16'sd100,    1'b0, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, -16'sd200,   1'b0, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 16'sh7FFF,   1'b0, 1'b1, '{16'sd100, 1'b0, 1'b0}},
		'{ROW_SAMPLE, '0, '0, 16'sh8000,   1'b0, 1'b1, '{-16'sd200, 1'b0, 1'b0}},
		'{ROW_SAMPLE, '0, '0, 16'sd5,      1'b0, 1'b1, '{16'sd0, 1'b1, 1'b0}},
		'{ROW_SAMPLE, '0, '0, 16'sd7,      1'b1, 1'b0, '0},
		'{ROW_WRITE, REG_LEFT_SPAN,  64'h0, '0, 1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_RIGHT_SPAN, 64'h0, '0, 1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_COEFF_B, 64'h4000_0000_0000_0000, '0, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 16'sh7FFF,   1'b0, 1'b1, '{16'sh7FFF, 1'b1, 1'b0}},
		'{ROW_SAMPLE, '0, '0, 16'sh8000,   1'b0, 1'b1, '{16'sh8000, 1'b1, 1'b0}},
		'{ROW_SAMPLE, '0, '0, 16'sd1,      1'b1, 1'b1, '{16'sd1, 1'b1, 1'b1}},
		'{ROW_WRITE, REG_COEFF_B, 64'h8000_0000_0000_0000, '0, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 16'sh8000,   1'b0, 1'b1, '{16'sh7FFF, 1'b1, 1'b0}},
		'{ROW_SAMPLE, '0, '0, 16'sh7FFF,   1'b0, 1'b1, '{16'sh8000, 1'b1, 1'b0}},
		'{ROW_SAMPLE, '0, '0, -16'sd1,     1'b0, 1'b1, '{16'sd2, 1'b1, 1'b0}},
		'{ROW_SAMPLE, '0, '0, 16'sd0,      1'b1, 1'b1, '{16'sd0, 1'b1, 1'b1}},
		'{ROW_WRITE, REG_COEFF_B, 64'h2000_0000_0000_0000, '0, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 16'sd1,      1'b0, 1'b1, '{16'sd1, 1'b1, 1'b0}},
		'{ROW_SAMPLE, '0, '0, -16'sd1,     1'b0, 1'b1, '{16'sd0, 1'b1, 1'b0}},
		'{ROW_SAMPLE, '0, '0, -16'sd3,     1'b1, 1'b1, '{-16'sd1, 1'b1, 1'b1}},
		'{ROW_WRITE, REG_LEFT_SPAN,  64'h7, '0, 1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_RIGHT_SPAN, 64'h7, '0, 1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_COEFF_A, 64'h7FFF_7FFF_7FFF_7FFF, '0, 1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_COEFF_B, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_COEFF_C, 64'h8000_8000_8000_8000, '0, 1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_COEFF_D, 64'h0000_FFFF_FFFF_FFFF, '0, 1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_SPARE_HI, 64'h0, '0, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 16'sd11,     1'b0, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, -16'sd12,    1'b0, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 16'sd13,     1'b1, 1'b0, '0}
	};

	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [SAMPLE_W-1:0]   s_axis_tdata  = '0;
	logic                  s_axis_tlast  = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [SAMPLE_W-1:0]   m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;

	span_t                     span_back  = SPAN_RESET;
	span_t                     span_ahead = SPAN_RESET;
	logic signed [COEFF_W-1:0] tap_coeff [NUM_TAPS];
	sample_t                   recent_samples [NUM_TAPS];
	logic [POS_W-1:0]          taken_count = '0;

	smooth_res_t step_results [$];
	smooth_res_t pending_results [$];
	int          error_count = 0;
	int          cycle_count = 0;
	bit          idle_on     = 1'b0;
	int          stall_left  = 0;

	savitzky_golay_stream_smoother DUT (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < NUM_TAPS; i++) begin
			tap_coeff[i] = '0;
			recent_samples[i] = '0;
		end
	end

	task automatic flag_error(input string what);
		if (error_count < 40)
			$display("ERROR at %0t: %s", $time, what);
		error_count++;
	endtask

	function automatic sample_t window_dot();
		longint acc;
		acc = 0;
		for (int k = -int'(span_back); k <= int'(span_ahead); k++)
			acc += longint'(tap_coeff[k + MAX_SPAN]) *
				longint'(recent_samples[int'(span_ahead) - k]);
		acc = (acc + (longint'(1) <<< (COEFF_FRAC - 1))) >>> COEFF_FRAC;
		if (acc > SAMPLE_MAX)
			acc = SAMPLE_MAX;
		if (acc < SAMPLE_MIN)
			acc = SAMPLE_MIN;
		return sample_t'(acc);
	endfunction

	task automatic advance_smoother(input sample_t x, input logic last);
		int back, ahead, taken, first;
		smooth_res_t res;
		back = span_back;
		ahead = span_ahead;
		taken = taken_count;
		step_results.delete();
		for (int i = NUM_TAPS - 1; i > 0; i--)
			recent_samples[i] = recent_samples[i - 1];
		recent_samples[0] = x;
		first = (taken >= ahead) ? ahead - 1 : taken;
		if (taken >= ahead) begin
			res.filt = (taken >= back + ahead);
			res.val = res.filt ? window_dot() : recent_samples[ahead];
			res.last = last && (first < 0);
			step_results.push_back(res);
		end
		if (last) begin
			for (int d = first; d >= 0; d--) begin
				res.val = recent_samples[d];
				res.filt = 1'b0;
				res.last = (d == 0);
				step_results.push_back(res);
			end
			taken_count = '0;
		end else if (taken < POS_MAX) begin
			taken_count = taken_count + POS_W'(1);
		end
	endtask

	task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_LEFT_SPAN: span_back = data[SPAN_W-1:0];
			REG_RIGHT_SPAN: span_ahead = data[SPAN_W-1:0];
			REG_COEFF_A: for (int i = 0; i < 4; i++) tap_coeff[i] = data[i*COEFF_W +: COEFF_W];
			REG_COEFF_B: for (int i = 0; i < 4; i++) tap_coeff[4 + i] = data[i*COEFF_W +: COEFF_W];
			REG_COEFF_C: for (int i = 0; i < 4; i++) tap_coeff[8 + i] = data[i*COEFF_W +: COEFF_W];
			REG_COEFF_D: for (int i = 0; i < 3; i++) tap_coeff[12 + i] = data[i*COEFF_W +: COEFF_W];
			default: ;
		endcase
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_write(idx, data);
	endtask

	task automatic send_sample(input sample_t x, input logic last);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= x;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		advance_smoother(x, last);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] rand_span_word();
		logic [CFG_DATA_W-1:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: w[SPAN_W-1:0] = '0;
			1: w[SPAN_W-1:0] = SPAN_W'(MAX_SPAN);
			default: w[SPAN_W-1:0] = SPAN_W'($urandom_range(0, MAX_SPAN));
		endcase
		return w;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_coeff_word();
		logic [CFG_DATA_W-1:0] w;
		int mag;
		w = '0;
		for (int s = 0; s < COEFF_PER_WORD; s++) begin
			mag = $urandom_range(0, 'h1800);
			case ($urandom_range(0, 5))
				0: w[s*COEFF_W +: COEFF_W] = '0;
				1: w[s*COEFF_W +: COEFF_W] = COEFF_W'($urandom);
				2: w[s*COEFF_W +: COEFF_W] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
				default: w[s*COEFF_W +: COEFF_W] = $urandom_range(0, 1) ? COEFF_W'(-mag) : COEFF_W'(mag);
			endcase
		end
		return w;
	endfunction

	function automatic sample_t rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			default: return sample_t'($urandom);
		endcase
	endfunction

	initial begin
		row_kind_e prev_kind;
		int random_sent;
		int len;
		bit first_phase;
		random_sent = 0;
		first_phase = 1'b1;
		prev_kind = ROW_WRITE;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b1;
		for (int r = 0; r < SCRIPT_LEN; r++) begin
			if (SCRIPT[r].kind == ROW_WRITE) begin
				if (prev_kind == ROW_SAMPLE)
					settle();
				write_reg(SCRIPT[r].idx, SCRIPT[r].data);
			end else begin
				if (prev_kind == ROW_WRITE)
					cfg_valid <= 1'b0;
				send_sample(SCRIPT[r].x, SCRIPT[r].last);
				if (SCRIPT[r].known)
					pending_results.push_back(SCRIPT[r].want);
				else
					foreach (step_results[i]) pending_results.push_back(step_results[i]);
			end
			prev_kind = SCRIPT[r].kind;
		end
		while (random_sent < RANDOM_SAMPLES) begin
			settle();
			idle_on = (random_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
			if (first_phase || $urandom_range(0, 1))
				write_reg(REG_LEFT_SPAN, rand_span_word());
			if (first_phase || $urandom_range(0, 1))
				write_reg(REG_RIGHT_SPAN, rand_span_word());
			if (first_phase || $urandom_range(0, 2) == 0)
				write_reg(REG_COEFF_A, rand_coeff_word());
			if (first_phase || $urandom_range(0, 2) == 0)
				write_reg(REG_COEFF_B, rand_coeff_word());
			if (first_phase || $urandom_range(0, 2) == 0)
				write_reg(REG_COEFF_C, rand_coeff_word());
			if (first_phase || $urandom_range(0, 2) == 0)
				write_reg(REG_COEFF_D, rand_coeff_word());
			if ($urandom_range(0, 7) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, {$urandom, $urandom});
			cfg_valid <= 1'b0;
			first_phase = 1'b0;
			repeat ($urandom_range(1, 4)) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 18);
				for (int i = 1; i <= len; i++) begin
					send_sample(rand_sample(), i == len);
					foreach (step_results[j]) pending_results.push_back(step_results[j]);
					random_sent++;
				end
			end
		end
		settle();
		if (error_count == 0)
			$display("** savitzky_golay_stream_smoother: PASSED **");
		else
			$display("** savitzky_golay_stream_smoother: FAILED **");
		$finish;
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= $urandom_range(0, 7);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		smooth_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				flag_error($sformatf("result %0d with none awaited", $signed(m_axis_tdata)));
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata !== want.val)
					flag_error($sformatf("sample %0d, want %0d", $signed(m_axis_tdata),
						want.val));
				if (m_axis_tuser !== want.filt)
					flag_error($sformatf("filtered flag %b, want %b", m_axis_tuser, want.filt));
				if (m_axis_tlast !== want.last)
					flag_error($sformatf("last flag %b, want %b", m_axis_tlast, want.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** savitzky_golay_stream_smoother: FAILED **");
			$finish;
		end
	end

endmodule
